@@ src/shp_pkg.sv @@
// Shared types and constants of the success-history parameter memory.
// Used by shp_div and the top level; depends on nothing.
package shp_pkg;

    localparam int MEMORY_SLOTS = 5;
    localparam int MAX_SUCCESS  = 1024;
    localparam int SLOT_W       = $clog2(MEMORY_SLOTS);
    localparam int CNT_W        = $clog2(MAX_SUCCESS + 1);
    localparam int ADDR_W       = $clog2(MAX_SUCCESS);
    localparam int ENTRY_W      = 64;  // {improvement, cr, sf}
    localparam int DIV_W        = 44;  // divisor and remainder width
    localparam int Q_W          = 17;  // quotient and shift-in width
    localparam int STEP_W       = 5;
    localparam int NUM_W        = 60;
    localparam int PROD_W       = 49;
    localparam logic [15:0] HALF_ONE = 16'd32768;

    localparam logic [1:0] REQ_RECORD = 2'd0;
    localparam logic [1:0] REQ_UPDATE = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISPATCH, ST_SUM_RD, ST_SUM_ACC, ST_W_RD, ST_W_DIV, ST_W_WAIT,
        ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4, ST_MUL5,
        ST_MSF_DIV, ST_MSF_WAIT, ST_MCR_DIV, ST_MCR_WAIT, ST_COMMIT, ST_EMIT
    } state_t;

    // Request to the shared divider.
    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  rem_init;
        logic [Q_W-1:0]    low_bits;
        logic [DIV_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ src/shp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module shp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/shp_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by weight and mean steps.
// Depends on shp_pkg for widths and the request/response structs.
module shp_div
    import shp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [Q_W-1:0]    low_reg, low_next;
    logic [DIV_W-1:0]  dvs_reg, dvs_next;
    logic [Q_W-1:0]    q_reg, q_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;

    // One restoring step per cycle
    always_comb begin
        trial     = {rem_reg, low_reg[Q_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        low_next  = low_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = req.rem_init;
            low_next  = req.low_bits;
            dvs_next  = req.divisor;
            q_next    = '0;
            cnt_next  = req.steps;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            low_next = {low_reg[Q_W-2:0], 1'b0};
            if (!diff[DIV_W]) begin
                rem_next = diff[DIV_W-1:0];
                q_next   = {q_reg[Q_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DIV_W-1:0];
                q_next   = {q_reg[Q_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        low_reg <= low_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

@@ src/success_history_param_memory.sv @@
// Top level of the success-history parameter memory: sequencer, ring and multiplier.
// Depends on shp_pkg, shp_ram and shp_div.
//
// Usage:
//   s_ channel carries request items: s_tuser is the request type (record, update,
//   read), s_tdata the success triple and the slot to read. m_ channel returns
//   slot means; m_tuser flags a record dropped because the list was full.
//   cfg_valid/cfg_data write the tolerance; cfg_ready is always high.
// Sequence:
//   One item at a time; s_tready is high only in the idle state.
//   Record and read: dispatch, then emit if there is a result, held while the output
//   register is occupied; a stored record and a read past the last slot give none.
//   Update with n entries: sum the improvements, then per entry a RAM read, a start,
//   17 divider steps and the multiply states, then two 16-step mean divisions and a
//   commit. The iterative divider and single 33x16 multiplier set an update's length.
// Reset: ring slots return to 0.5, the success list empties, the slot pointer
//   and tolerance return to 0 and 1. The list RAM needs no clearing.
// Stall: a result waits in the output register until m_tready; a new result holds
//   the sequencer in its emit state while the register is still occupied.
module success_history_param_memory
    import shp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // sf[15:0], cr[31:16], improvement[63:32],
                                   // viol_worse[64], slot[67:65], zero fill
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // mean_sf[15:0], mean_cr[31:16], slot_index[34:32],
                                   // zero fill
    output logic        m_tuser,   // list_full[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    state_t state_reg, state_next;
    logic [15:0]      tol_reg, tol_next;
    logic [1:0]       req_reg, req_next;
    logic [15:0]      isf_reg, isf_next;
    logic [15:0]      icr_reg, icr_next;
    logic [31:0]      iimp_reg, iimp_next;
    logic             iworse_reg, iworse_next;
    logic [2:0]       islot_reg, islot_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [SLOT_W-1:0] wslot_reg, wslot_next;
    logic [DIV_W-1:0] sum_reg, sum_next;
    logic [Q_W-1:0]   w_reg, w_next;
    logic [15:0]      xs_reg, xs_next;
    logic [15:0]      xc_reg, xc_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [NUM_W-1:0] nsf_reg, nsf_next;
    logic [DIV_W-1:0] dsf_reg, dsf_next;
    logic [NUM_W-1:0] ncr_reg, ncr_next;
    logic [DIV_W-1:0] dcr_reg, dcr_next;
    logic [15:0]      newsf_reg, newsf_next;
    logic [15:0]      osf_reg, osf_next;
    logic [15:0]      ocr_reg, ocr_next;
    logic [2:0]       oslot_reg, oslot_next;
    logic             ofull_reg, ofull_next;
    logic             mvalid_reg;
    logic [15:0]      msf_reg [MEMORY_SLOTS];
    logic [15:0]      msf_next [MEMORY_SLOTS];
    logic [15:0]      mcr_reg [MEMORY_SLOTS];
    logic [15:0]      mcr_next [MEMORY_SLOTS];

    logic               ram_we;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [32:0]        mul_a;
    logic [15:0]        mul_b;
    logic               out_free;
    logic               emit_fire;
    logic [DIV_W-1:0]   sum_acc;
    logic [16:0]        fold;
    div_req_t           dreq;
    div_rsp_t           drsp;

    // List RAM: {improvement, cr, sf}
    shp_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SUCCESS)) u_list (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (ram_wdata),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    shp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    assign out_free  = !mvalid_reg || m_tready;
    assign emit_fire = (state_reg == ST_EMIT) && out_free;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign ram_wdata = {(iworse_reg ? {16'd0, tol_reg} : iimp_reg), icr_reg, isf_reg};

    // Sequencer: next state, datapath selects and register updates
    always_comb begin
        state_next  = state_reg;
        tol_next    = cfg_valid ? cfg_data : tol_reg;
        req_next    = req_reg;
        isf_next    = isf_reg;
        icr_next    = icr_reg;
        iimp_next   = iimp_reg;
        iworse_next = iworse_reg;
        islot_next  = islot_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        wslot_next  = wslot_reg;
        sum_next    = sum_reg;
        w_next      = w_reg;
        xs_next     = xs_reg;
        xc_next     = xc_reg;
        nsf_next    = nsf_reg;
        dsf_next    = dsf_reg;
        ncr_next    = ncr_reg;
        dcr_next    = dcr_reg;
        newsf_next  = newsf_reg;
        osf_next    = osf_reg;
        ocr_next    = ocr_reg;
        oslot_next  = oslot_reg;
        ofull_next  = ofull_reg;
        msf_next    = msf_reg;
        mcr_next    = mcr_reg;
        ram_we      = 1'b0;
        mul_a       = {16'd0, w_reg};
        mul_b       = xs_reg;
        sum_acc     = sum_reg + {12'd0, ram_rdata[63:32]};
        fold        = {1'b0, drsp.quotient[15:0]} + {1'b0, msf_reg[wslot_reg]};
        dreq.start    = 1'b0;
        dreq.rem_init = {13'd0, ram_rdata[63:33]};
        dreq.low_bits = {ram_rdata[32], 16'd0};
        dreq.divisor  = sum_reg;
        dreq.steps    = STEP_W'(Q_W);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    req_next    = s_tuser;
                    isf_next    = s_tdata[15:0];
                    icr_next    = s_tdata[31:16];
                    iimp_next   = s_tdata[63:32];
                    iworse_next = s_tdata[64];
                    islot_next  = s_tdata[67:65];
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                state_next = ST_IDLE;
                case (req_reg)
                    REQ_RECORD: begin
                        if (count_reg >= CNT_W'(MAX_SUCCESS)) begin
                            osf_next   = '0;
                            ocr_next   = '0;
                            oslot_next = '0;
                            ofull_next = 1'b1;
                            state_next = ST_EMIT;
                        end else begin
                            ram_we     = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    REQ_UPDATE: begin
                        if (count_reg != '0) begin
                            idx_next   = '0;
                            sum_next   = '0;
                            nsf_next   = '0;
                            dsf_next   = '0;
                            ncr_next   = '0;
                            dcr_next   = '0;
                            state_next = ST_SUM_RD;
                        end
                    end
                    REQ_READ: begin
                        if (islot_reg < 3'(MEMORY_SLOTS)) begin
                            osf_next   = msf_reg[islot_reg[SLOT_W-1:0]];
                            ocr_next   = mcr_reg[islot_reg[SLOT_W-1:0]];
                            oslot_next = islot_reg;
                            ofull_next = 1'b0;
                            state_next = ST_EMIT;
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            // Sum the improvements, a read state and an accumulate state per entry
            ST_SUM_RD: begin
                state_next = ST_SUM_ACC;
            end
            ST_SUM_ACC: begin
                sum_next = sum_acc;
                if (idx_reg + 1'b1 == count_reg) begin
                    if (sum_acc == '0) begin
                        sum_next = {28'd0, tol_reg};
                    end
                    idx_next   = '0;
                    state_next = ST_W_RD;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SUM_RD;
                end
            end
            // Weight of one entry through the divider
            ST_W_RD: begin
                state_next = ST_W_DIV;
            end
            ST_W_DIV: begin
                xs_next    = ram_rdata[15:0];
                xc_next    = ram_rdata[31:16];
                dreq.start = 1'b1;
                state_next = ST_W_WAIT;
            end
            ST_W_WAIT: begin
                if (drsp.done) begin
                    w_next     = (drsp.quotient == '0) ? {1'b0, tol_reg} : drsp.quotient;
                    state_next = ST_MUL1;
                end
            end
            // Accumulate w*x and w*x*x through the one multiplier
            ST_MUL1: begin
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                dsf_next   = dsf_reg + DIV_W'(prod_reg[32:0]);
                mul_a      = prod_reg[32:0];
                state_next = ST_MUL3;
            end
            ST_MUL3: begin
                nsf_next   = nsf_reg + NUM_W'(prod_reg);
                mul_b      = xc_reg;
                state_next = ST_MUL4;
            end
            ST_MUL4: begin
                dcr_next   = dcr_reg + DIV_W'(prod_reg[32:0]);
                mul_a      = prod_reg[32:0];
                mul_b      = xc_reg;
                state_next = ST_MUL5;
            end
            ST_MUL5: begin
                ncr_next = ncr_reg + NUM_W'(prod_reg);
                if (idx_reg + 1'b1 == count_reg) begin
                    state_next = ST_MSF_DIV;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_W_RD;
                end
            end
            // Lehmer means, folded with the old slot value
            ST_MSF_DIV: begin
                dreq.start    = 1'b1;
                dreq.rem_init = nsf_reg[NUM_W-1:16];
                dreq.low_bits = {nsf_reg[15:0], 1'b0};
                dreq.divisor  = (dsf_reg == '0) ? {28'd0, tol_reg} : dsf_reg;
                dreq.steps    = STEP_W'(16);
                state_next    = ST_MSF_WAIT;
            end
            ST_MSF_WAIT: begin
                if (drsp.done) begin
                    newsf_next = fold[16:1];
                    state_next = ST_MCR_DIV;
                end
            end
            ST_MCR_DIV: begin
                dreq.start    = 1'b1;
                dreq.rem_init = ncr_reg[NUM_W-1:16];
                dreq.low_bits = {ncr_reg[15:0], 1'b0};
                dreq.divisor  = (dcr_reg == '0) ? {28'd0, tol_reg} : dcr_reg;
                dreq.steps    = STEP_W'(16);
                state_next    = ST_MCR_WAIT;
            end
            ST_MCR_WAIT: begin
                fold = {1'b0, drsp.quotient[15:0]} + {1'b0, mcr_reg[wslot_reg]};
                if (drsp.done) begin
                    ocr_next   = fold[16:1];
                    state_next = ST_COMMIT;
                end
            end
            // Write the slot back, advance the pointer, clear the list
            ST_COMMIT: begin
                msf_next[wslot_reg] = newsf_reg;
                mcr_next[wslot_reg] = ocr_reg;
                osf_next   = newsf_reg;
                oslot_next = 3'(wslot_reg);
                ofull_next = 1'b0;
                wslot_next = (wslot_reg == SLOT_W'(MEMORY_SLOTS - 1)) ? '0
                                                                    : wslot_reg + 1'b1;
                count_next = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        prod_next = PROD_W'(mul_a * mul_b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tol_reg   <= 16'd1;
            count_reg <= '0;
            wslot_reg <= '0;
            for (int k = 0; k < MEMORY_SLOTS; k++) begin
                msf_reg[k] <= HALF_ONE;
                mcr_reg[k] <= HALF_ONE;
            end
        end else begin
            state_reg <= state_next;
            tol_reg   <= tol_next;
            count_reg <= count_next;
            wslot_reg <= wslot_next;
            msf_reg   <= msf_next;
            mcr_reg   <= mcr_next;
        end
        req_reg    <= req_next;
        isf_reg    <= isf_next;
        icr_reg    <= icr_next;
        iimp_reg   <= iimp_next;
        iworse_reg <= iworse_next;
        islot_reg  <= islot_next;
        idx_reg    <= idx_next;
        sum_reg    <= sum_next;
        w_reg      <= w_next;
        xs_reg     <= xs_next;
        xc_reg     <= xc_next;
        prod_reg   <= prod_next;
        nsf_reg    <= nsf_next;
        dsf_reg    <= dsf_next;
        ncr_reg    <= ncr_next;
        dcr_reg    <= dcr_next;
        newsf_reg  <= newsf_next;
        osf_reg    <= osf_next;
        ocr_reg    <= ocr_next;
        oslot_reg  <= oslot_next;
        ofull_reg  <= ofull_next;
    end

    // Output register: load on emit, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (emit_fire) begin
            mvalid_reg <= 1'b1;
        end else if (m_tready) begin
            mvalid_reg <= 1'b0;
        end
        if (emit_fire) begin
            m_tdata <= {5'd0, oslot_reg, ocr_reg, osf_reg};
            m_tuser <= ofull_reg;
        end
    end

    assign m_tvalid = mvalid_reg;

endmodule
